[hdl/fstc_pkg.sv]
package fstc_pkg;

  // default line length and circle geometry
  localparam int unsigned MaxWidthDefault = 2048;
  localparam int unsigned NumCirc         = 16;
  localparam int unsigned WinDim          = 7;
  localparam int unsigned RowBytes        = 6;
  localparam logic [7:0]  PixMax          = 8'hFF;

  // circle offsets, clockwise from the top
  localparam int CircDy [NumCirc] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
  localparam int CircDx [NumCirc] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

  // register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2,
    CFG_ARC    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] width;
    logic [15:0] height;
    logic [7:0]  thresh;
    logic [4:0]  arc;
  } cfg_t;

  // per-pixel control that travels with the line buffer request
  typedef struct packed {
    logic                 res;
    logic                 last;
    logic [7:0]           fresh;
    logic [NumCirc-1:0]   in_img;
  } item_t;

endpackage

[hdl/fstc_ctrl.sv]
module fstc_ctrl #(
  parameter int unsigned MaxWidth = fstc_pkg::MaxWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_kind_i,
  input  logic [7:0]                    in_pixel_i,
  input  logic                          a_free_i,
  output logic                          adv_o,
  output logic [$clog2(MaxWidth)-1:0]   addr_o,
  output fstc_pkg::item_t               item_o,
  output logic [7:0]                    thresh_o,
  output logic [4:0]                    arc_o
);
  import fstc_pkg::*;

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned RW = 17;
  localparam int unsigned PW = WW + RW;

  cfg_t           cfg_q;
  logic           settle_q;
  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;
  logic [15:0]    out_row_q, out_row_d;
  logic [PW-1:0]  pos_q, pos_d, opos_q, opos_d, total_q;
  logic [WW-1:0]  w_eff;
  logic [15:0]    h_eff;
  logic [PW-1:0]  thr;
  logic           acc, in_ok, drop, adv, res, last;
  logic [WW:0]    col_p1, ocol_p1;
  logic [6:0]     row_ok, col_ok;
  logic [17:0]    row_sh;
  logic [WW+1:0]  col_sh;
  logic [NumCirc-1:0] circ_in;

  // configuration registers, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 12'd640;
      cfg_q.height <= 16'd480;
      cfg_q.thresh <= 8'd20;
      cfg_q.arc    <= 5'd9;
      settle_q     <= 1'b1;
    end else begin
      settle_q <= cfg_valid_i;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:  cfg_q.width  <= cfg_data_i[11:0];
          CFG_HEIGHT: cfg_q.height <= cfg_data_i;
          CFG_THRESH: cfg_q.thresh <= cfg_data_i[7:0];
          CFG_ARC:    cfg_q.arc    <= cfg_data_i[4:0];
          default:    cfg_q        <= cfg_q;
        endcase
      end
    end
  end

  // effective geometry
  always_comb begin
    if (cfg_q.width == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_q.width) > MaxWidth) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(cfg_q.width);
    end
    h_eff = (cfg_q.height == 16'd0) ? 16'd1 : cfg_q.height;
    thr   = (PW'(w_eff) << 1) + PW'(w_eff) + PW'(3);
  end

  assign thresh_o = cfg_q.thresh;
  assign arc_o    = cfg_q.arc;

  // request decode
  assign in_ready_o = !settle_q && a_free_i;
  assign acc        = in_valid_i && in_ready_o;
  assign in_ok      = pos_q < total_q;
  assign drop       = in_kind_i && in_ok;
  assign adv        = acc && !drop;
  assign res        = pos_q >= thr;
  assign col_p1     = (WW+1)'(in_col_q) + (WW+1)'(1);
  assign ocol_p1    = (WW+1)'(out_col_q) + (WW+1)'(1);

  // circle rows and columns that fall inside the frame
  always_comb begin
    for (int d = 0; d < 7; d++) begin
      row_sh    = 18'(out_row_q) + 18'(d);
      col_sh    = (WW+2)'(out_col_q) + (WW+2)'(d);
      row_ok[d] = (row_sh >= 18'd3) && (row_sh < 18'(h_eff) + 18'd3);
      col_ok[d] = (col_sh >= (WW+2)'(3)) && (col_sh < (WW+2)'(w_eff) + (WW+2)'(3));
    end
    for (int k = 0; k < NumCirc; k++) begin
      circ_in[k] = row_ok[CircDy[k] + 3] && col_ok[CircDx[k] + 3];
    end
  end

  // position counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    pos_d     = pos_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    opos_d    = opos_q;
    last      = 1'b0;
    if (adv) begin
      if (col_p1 >= (WW+1)'(w_eff)) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
        pos_d    = pos_q + PW'(w_eff) - PW'(in_col_q);
      end else begin
        in_col_d = CW'(col_p1);
        pos_d    = pos_q + PW'(1);
      end
      if (res) begin
        if (ocol_p1 >= (WW+1)'(w_eff)) begin
          out_col_d = '0;
          out_row_d = out_row_q + 16'd1;
          opos_d    = opos_q + PW'(w_eff) - PW'(out_col_q);
        end else begin
          out_col_d = CW'(ocol_p1);
          opos_d    = opos_q + PW'(1);
        end
        last = opos_d >= total_q;
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          pos_d     = '0;
          out_col_d = '0;
          out_row_d = '0;
          opos_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pos_q     <= '0;
      opos_q    <= '0;
    end else if (settle_q) begin
      pos_q  <= PW'(in_row_q) * PW'(w_eff) + PW'(in_col_q);
      opos_q <= PW'(out_row_q) * PW'(w_eff) + PW'(out_col_q);
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pos_q     <= pos_d;
      opos_q    <= opos_d;
    end
  end

  // frame size product, refreshed after each register write
  always_ff @(posedge clk_i) begin
    if (settle_q) begin
      total_q <= PW'(w_eff) * PW'(h_eff);
    end
  end

  assign adv_o         = adv;
  assign addr_o        = in_col_q;
  assign item_o.res    = res;
  assign item_o.last   = last;
  assign item_o.fresh  = (!in_kind_i && in_ok) ? in_pixel_i : 8'd0;
  assign item_o.in_img = circ_in;

endmodule

[hdl/fstc_linebuf.sv]
module fstc_linebuf #(
  parameter int unsigned MaxWidth = fstc_pkg::MaxWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [$clog2(MaxWidth)-1:0]   addr_i,
  input  fstc_pkg::item_t               item_i,
  input  logic                          a_go_i,
  input  logic [7:0]                    thresh_i,
  output logic                          a_res_o,
  output logic [fstc_pkg::NumCirc-1:0]  bright_o,
  output logic [fstc_pkg::NumCirc-1:0]  dark_o,
  output logic                          last_o
);
  import fstc_pkg::*;

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned MW = 8 * RowBytes;

  logic [MW-1:0]  mem [MaxWidth];
  logic [MW-1:0]  rdata_q, fwd_data_q, old_row, wdata;
  logic           fwd_q;
  logic [CW-1:0]  addr_q;
  item_t          item_q;
  logic [7:0]     win_q [WinDim][WinDim];
  logic [7:0]     win_d [WinDim][WinDim];
  logic [NumCirc-1:0] bright_d, dark_d, bright_q, dark_q;
  logic           last_q;
  logic [7:0]     centre, upper, lower, v;
  logic [8:0]     sum;

  // row store: read on request, written back when the item leaves
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go_i) begin
      mem[addr_q] <= wdata;
    end
  end

  // forward a write that lands on the entry read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (adv_i) begin
      fwd_q <= a_go_i && (addr_q == addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_data_q <= wdata;
      addr_q     <= addr_i;
      item_q     <= item_i;
    end
  end

  assign old_row = fwd_q ? fwd_data_q : rdata_q;
  assign wdata   = {item_q.fresh, old_row[MW-1:8]};
  assign a_res_o = item_q.res;

  // window shift with the new column
  always_comb begin
    for (int i = 0; i < WinDim; i++) begin
      for (int j = 0; j < WinDim - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
    end
    for (int i = 0; i < RowBytes; i++) begin
      win_d[i][WinDim-1] = old_row[8*i +: 8];
    end
    win_d[WinDim-1][WinDim-1] = item_q.fresh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinDim; i++) begin
        for (int j = 0; j < WinDim; j++) begin
          win_q[i][j] <= 8'd0;
        end
      end
    end else if (a_go_i) begin
      win_q <= win_d;
    end
  end

  // brighter and darker masks around the centre
  always_comb begin
    centre = win_d[3][3];
    sum    = 9'(centre) + 9'(thresh_i);
    upper  = sum[8] ? PixMax : sum[7:0];
    lower  = (centre > thresh_i) ? (centre - thresh_i) : 8'd0;
    v      = 8'd0;
    for (int k = 0; k < NumCirc; k++) begin
      v           = item_q.in_img[k] ? win_d[3 + CircDy[k]][3 + CircDx[k]] : 8'd0;
      bright_d[k] = v > upper;
      dark_d[k]   = v < lower;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go_i && item_q.res) begin
      bright_q <= bright_d;
      dark_q   <= dark_d;
      last_q   <= item_q.last;
    end
  end

  assign bright_o = bright_q;
  assign dark_o   = dark_q;
  assign last_o   = last_q;

endmodule

[hdl/fstc_arc.sv]
module fstc_arc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [fstc_pkg::NumCirc-1:0]  bright_i,
  input  logic [fstc_pkg::NumCirc-1:0]  dark_i,
  input  logic                          last_i,
  input  logic [4:0]                    arc_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_is_corner_o,
  output logic                          out_frame_end_o
);
  import fstc_pkg::*;

  logic               out_valid_q;
  logic               corner_q, end_q;
  logic [4:0]         arc_eff;
  logic [NumCirc-1:0] br_acc, dk_acc;

  // circular run test: some start bit and the arc_eff - 1 bits after it are all set
  always_comb begin
    if (arc_i == 5'd0) begin
      arc_eff = 5'd1;
    end else if (arc_i > 5'(NumCirc)) begin
      arc_eff = 5'(NumCirc);
    end else begin
      arc_eff = arc_i;
    end
    br_acc = bright_i;
    dk_acc = dark_i;
    for (int k = 1; k < NumCirc; k++) begin
      if (5'(k) < arc_eff) begin
        br_acc = br_acc & ((bright_i >> k) | (bright_i << (NumCirc - k)));
        dk_acc = dk_acc & ((dark_i >> k) | (dark_i << (NumCirc - k)));
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      corner_q <= (|br_acc) || (|dk_acc);
      end_q    <= last_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_is_corner_o = corner_q;
  assign out_frame_end_o = end_q;

endmodule

[hdl/fast_segment_test_corner.sv]
// segment-test corner detector for a raster stream of 8-bit gray pixels. one
// request per clock is taken in steady state while the output is not stalled;
// each request does one read and one write of the two-port row store (MaxWidth
// entries of six stored rows) and one shift of the 7x7 window, and its result
// passes the line buffer stage, the mask register and the output register. the
// result for a pixel trails the input by 3 rows and 3 pixels, so flush requests
// (kind 1) after the last pixel drain the final rows; a flush before the frame
// is complete is taken and dropped. after reset and after every register write
// the input is held off while the frame size and stream positions are
// recomputed.
module fast_segment_test_corner #(
  parameter int unsigned MaxWidth = fstc_pkg::MaxWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_kind_i,
  input  logic [7:0]  in_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_is_corner_o,
  output logic        out_frame_end_o
);
  import fstc_pkg::*;

  logic                        a_valid_q, b_valid_q;
  logic                        adv, a_go, a_free, a_res, b_free, b_go, out_free;
  logic [$clog2(MaxWidth)-1:0] addr;
  item_t                       item;
  logic [7:0]                  thresh;
  logic [4:0]                  arc;
  logic [NumCirc-1:0]          bright, dark;
  logic                        last;

  // pipeline flow: each stage moves when the next one has room, and an item with no result leaves stage a without it
  assign out_free = !out_valid_o || out_ready_i;
  assign b_go     = b_valid_q && out_free;
  assign b_free   = !b_valid_q || out_free;
  assign a_go     = a_valid_q && (!a_res || b_free);
  assign a_free   = !a_valid_q || a_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        a_valid_q <= 1'b1;
      end else if (a_go) begin
        a_valid_q <= 1'b0;
      end
      if (a_go && a_res) begin
        b_valid_q <= 1'b1;
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  fstc_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_kind_i  (in_kind_i),
    .in_pixel_i (in_pixel_i),
    .a_free_i   (a_free),
    .adv_o      (adv),
    .addr_o     (addr),
    .item_o     (item),
    .thresh_o   (thresh),
    .arc_o      (arc)
  );

  fstc_linebuf #(.MaxWidth(MaxWidth)) u_linebuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .addr_i  (addr),
    .item_i  (item),
    .a_go_i  (a_go),
    .thresh_i(thresh),
    .a_res_o (a_res),
    .bright_o(bright),
    .dark_o  (dark),
    .last_o  (last)
  );

  fstc_arc u_arc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (b_go),
    .bright_i       (bright),
    .dark_i         (dark),
    .last_i         (last),
    .arc_i          (arc),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_is_corner_o(out_is_corner_o),
    .out_frame_end_o(out_frame_end_o)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import fstc_pkg::*;

  localparam int unsigned LineMax    = 2048;
  localparam int unsigned CycleLimit = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i = CFG_WIDTH;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        in_kind_i = 1'b0;
  logic [7:0]  in_pixel_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        out_is_corner_o;
  logic        out_frame_end_o;

  fast_segment_test_corner i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_kind_i, .in_pixel_i,
    .out_valid_o, .out_ready_i, .out_is_corner_o, .out_frame_end_o
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic corner;
    logic frame_end;
  } corner_res_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pix;
    logic       typed;
    logic       corner;
    logic       frame_end;
  } stim_row_t;

  corner_res_t pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          n_sent = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          tx_gap = 0;
  int          rx_stall = 0;

  // shadow of the detector state
  logic [47:0] line_mem [LineMax];
  logic [7:0]  win [7][7];
  int unsigned col_in, row_in, col_out, row_out;
  logic [11:0] reg_width = 12'd640;
  logic [15:0] reg_height = 16'd480;
  logic [7:0]  reg_thresh = 8'd20;
  logic [4:0]  reg_arc = 5'd9;
  bit          frame_done;

  function automatic int unsigned width_eff();
    if (reg_width == 0) return 1;
    if (reg_width > LineMax) return LineMax;
    return reg_width;
  endfunction

  function automatic int unsigned height_eff();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  // longest circular run of ones in the 16-bit circle mask
  function automatic int unsigned arc_run(logic [15:0] m);
    int unsigned run, best;
    run = 0;
    best = 0;
    for (int i = 0; i < 32; i++) begin
      if (m[i % 16]) begin
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    return (best > 16) ? 16 : best;
  endfunction

  function automatic logic corner_test(int unsigned w, int unsigned h);
    int unsigned ctr, upper, lower, v, need;
    int          ry, cx;
    logic [15:0] bright, dark;
    ctr = win[3][3];
    upper = (ctr + reg_thresh > 255) ? 255 : ctr + reg_thresh;
    lower = (ctr > reg_thresh) ? ctr - reg_thresh : 0;
    bright = '0;
    dark = '0;
    for (int k = 0; k < 16; k++) begin
      ry = int'(row_out) + CircDy[k];
      cx = int'(col_out) + CircDx[k];
      v = 0;
      if (ry >= 0 && ry < int'(h) && cx >= 0 && cx < int'(w))
        v = win[3 + CircDy[k]][3 + CircDx[k]];
      bright[k] = (v > upper);
      dark[k] = (v < lower);
    end
    need = (reg_arc == 0) ? 1 : (reg_arc > 16) ? 16 : reg_arc;
    return (arc_run(bright) >= need) || (arc_run(dark) >= need);
  endfunction

  // advance the shadow by one accepted request
  function automatic bit corner_step(logic kind, logic [7:0] pix, output corner_res_t res);
    int unsigned w, h;
    longint unsigned total, pos;
    logic [7:0]  fresh;
    logic [47:0] old;
    w = width_eff();
    h = height_eff();
    total = longint'(w) * h;
    pos = longint'(row_in) * w + col_in;
    res = '0;
    if (kind && pos < total) return 1'b0;
    fresh = (!kind && pos < total) ? pix : 8'd0;
    old = line_mem[col_in % LineMax];
    for (int i = 0; i < 7; i++)
      for (int j = 0; j < 6; j++) win[i][j] = win[i][j+1];
    for (int i = 0; i < 6; i++) win[i][6] = old[8*i +: 8];
    win[6][6] = fresh;
    line_mem[col_in % LineMax] = {fresh, old[47:8]};
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (pos < 3 * longint'(w) + 3) return 1'b0;
    res.corner = corner_test(w, h);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    res.frame_end = (longint'(row_out) * w + col_out >= total);
    if (res.frame_end) begin
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      frame_done = 1'b1;
    end
    return 1'b1;
  endfunction

  // one pixel request through the handshake, prediction on acceptance
  task automatic send_px(logic kind, logic [7:0] pix, bit typed = 0,
                         corner_res_t typed_res = '0);
    corner_res_t res;
    repeat (tx_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_pixel_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
    if (corner_step(kind, pix, res)) begin
      pending_q.push_back(typed ? typed_res : res);
    end else if (typed) begin
      $display("%0t: expected a result for request %b/%0d, none predicted", $realtime,
               kind, pix);
      errors++;
    end
    tx_gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (tx_gap > 0) in_valid_i <= 1'b0;
  endtask

  // register write, only with the block idle
  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    if (tx_gap == 0) in_valid_i <= 1'b0;
    tx_gap = 0;
    wait (pending_q.size() == 0);
    repeat (12) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH:  reg_width = data[11:0];
      CFG_HEIGHT: reg_height = data;
      CFG_THRESH: reg_thresh = data[7:0];
      default:    reg_arc = data[4:0];
    endcase
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [7:0] t, logic [4:0] a);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_THRESH, {8'd0, t});
    write_reg(CFG_ARC, {11'd0, a});
  endtask

  // full frame with random content, then drain
  task automatic run_frame(int style);
    int unsigned n;
    logic [7:0]  p;
    n = width_eff() * height_eff();
    frame_done = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 40) == 0) send_px(1'b1, 8'($urandom));
      case (style)
        0:       p = 8'($urandom);
        1:       p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: p = $urandom_range(0, 6) == 0 ? 8'($urandom) : 8'd128;
      endcase
      send_px(1'b0, p);
    end
    while (!frame_done) send_px($urandom_range(0, 9) != 0, 8'($urandom));
  endtask

  // result side: random stall, check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result corner=%b end=%b", $realtime,
                   out_is_corner_o, out_frame_end_o);
          errors++;
        end else begin
          corner_res_t exp_r;
          exp_r = pending_q.pop_front();
          if (exp_r.corner !== out_is_corner_o) begin
            $display("%0t: is_corner expected %b actual %b", $realtime, exp_r.corner,
                     out_is_corner_o);
            errors++;
          end
          if (exp_r.frame_end !== out_frame_end_o) begin
            $display("%0t: frame_end expected %b actual %b", $realtime, exp_r.frame_end,
                     out_frame_end_o);
            errors++;
          end
        end
        rx_stall = rx_burst ? 0 : $urandom_range(0, 18);
        if (rx_stall > 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (rx_stall == 0) out_ready_i <= 1'b1;
        else rx_stall--;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  stim_row_t directed [22] = '{
    // flush before the frame: dropped
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    // bright centre in a 1x1 frame, all circle pixels outside read as zero
    '{1'b0, 8'd255, 1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    // pixel after frame end acts as flush
    '{1'b0, 8'd77,  1'b1, 1'b1, 1'b1},
    // zero centre: nothing darker
    '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b1, 1'b0, 1'b1},
    // centre equal to threshold: lower bound saturates to zero
    '{1'b0, 8'd20,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   1'b1, 1'b0, 1'b1}
  };

  // main sequence
  initial begin
    for (int i = 0; i < LineMax; i++) line_mem[i] = '0;
    for (int i = 0; i < 7; i++)
      for (int j = 0; j < 7; j++) win[i][j] = '0;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    set_frame(16'd1, 16'd1, 8'd20, 5'd9);
    foreach (directed[i])
      send_px(directed[i].kind, directed[i].pix, directed[i].typed,
              '{directed[i].corner, directed[i].frame_end});

    // register extremes, out-of-range values included
    set_frame(16'd0, 16'd0, 8'd0, 5'd0);
    run_frame(0);
    set_frame(16'd7, 16'd5, 8'd255, 5'd31);
    run_frame(1);
    set_frame(16'd9, 16'd6, 8'd0, 5'd16);
    run_frame(1);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    // upper data bits beyond the width field are dropped
    set_frame(16'hF005, 16'd3, 8'd40, 5'd1);
    run_frame(0);
    set_frame(16'd1, 16'd12, 8'd10, 5'd12);
    run_frame(2);

    // random frames
    while (n_sent < 1500) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      set_frame($urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 40))
                                          : 16'($urandom_range(1, 12)),
                16'($urandom_range(0, 9)),
                $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 60)),
                5'($urandom_range(0, 31)));
      run_frame($urandom_range(0, 2));
    end

    if (tx_gap == 0) in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
